// File: hw/rtl/rbsi_pkg.sv
package rbsi_pkg;

  localparam int FieldBits = 32;
  localparam int LimitBits = 31;
  localparam int SatBits   = 48;

  typedef enum logic [1:0] {
    STATUS_MISS    = 2'd0,
    STATUS_HIT     = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    MODE_LOAD = 1'b0,
    MODE_TEST = 1'b1
  } mode_t;

  typedef struct packed {
    logic                        mode;
    logic signed [FieldBits-1:0] first_x;
    logic signed [FieldBits-1:0] first_y;
    logic signed [FieldBits-1:0] first_z;
    logic signed [FieldBits-1:0] second_x;
    logic signed [FieldBits-1:0] second_y;
    logic signed [FieldBits-1:0] second_z;
    logic [LimitBits-1:0]        limit;
  } item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [LimitBits-1:0] t_enter;
  } result_t;

endpackage

// File: hw/rtl/rbsi_item_if.sv
interface rbsi_item_if;
  import rbsi_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/rbsi_result_if.sv
interface rbsi_result_if;
  import rbsi_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/rbsi_queue.sv
module rbsi_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  // Two-entry queue between the front and back ends.
  logic [WIDTH-1:0] slot [2];
  logic             rd_ptr;
  logic             wr_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_data;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: hw/rtl/rbsi_divider.sv
module rbsi_divider #(
  parameter int NUM_BITS = 33,
  parameter int DEN_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num_mag,
  input  logic [DEN_BITS-1:0] den_mag,
  output logic                done,
  output logic [NUM_BITS+FRAC_BITS-1:0] quot,
  output logic                rem_nz
);
  // Radix-2 restoring divider of (num << FRAC_BITS) / den, one bit a cycle.
  localparam int QBITS = NUM_BITS + FRAC_BITS;
  localparam int CBITS = $clog2(QBITS + 1);

  logic [QBITS-1:0]  dividend;
  logic [DEN_BITS:0] rem;
  logic [DEN_BITS-1:0] den;
  logic [CBITS-1:0]  count;
  logic              busy;
  logic [DEN_BITS:0] shifted;
  logic [DEN_BITS:0] diff;

  assign shifted = {rem[DEN_BITS-1:0], dividend[QBITS-1]};
  assign diff    = shifted - {1'b0, den};
  assign rem_nz  = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        dividend <= {num_mag, {FRAC_BITS{1'b0}}};
        den      <= den_mag;
        rem      <= '0;
        quot     <= '0;
        count    <= CBITS'(QBITS);
      end else if (busy) begin
        dividend <= {dividend[QBITS-2:0], 1'b0};
        if (!diff[DEN_BITS]) begin
          rem  <= diff;
          quot <= {quot[QBITS-2:0], 1'b1};
        end else begin
          rem  <= shifted;
          quot <= {quot[QBITS-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CBITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/rbsi_back.sv
module rbsi_back #(
  parameter int COORD_BITS = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rbsi_pkg::item_t      in_data,
  rbsi_result_if.source        res
);
  import rbsi_pkg::*;

  localparam int CW = (COORD_BITS < FieldBits) ? COORD_BITS : FieldBits;
  localparam int NB = CW + 1;
  localparam int QB = NB + FRACTION_BITS;
  localparam int WB = (QB > SatBits) ? QB + 1 : SatBits + 1;
  localparam logic signed [WB-1:0] SatMax = WB'((64'sd1 <<< (SatBits - 1)) - 1);
  localparam logic signed [WB-1:0] SatMin = -WB'(64'sd1 <<< (SatBits - 1));

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_AXIS  = 6'b000100,
    S_WAIT  = 6'b001000,
    S_MERGE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];
  logic [LimitBits-1:0] lim;
  logic signed [CW-1:0] lo [3];
  logic signed [CW-1:0] hi [3];
  logic [1:0]           axis;
  logic                 second;
  logic signed [WB-1:0] t_min;
  logic signed [WB-1:0] t_max;
  logic signed [WB-1:0] p_val;
  logic [1:0]           status;
  logic [LimitBits-1:0] t_out;

  logic signed [NB-1:0] num;
  logic signed [CW-1:0] den_s;
  logic [NB-1:0]        num_mag;
  logic [CW-1:0]        den_mag;
  logic                 neg;
  logic                 num_zero;
  logic                 start;
  logic                 done;
  logic [QB-1:0]        quot;
  logic                 rem_nz;
  logic signed [WB-1:0] slab;
  logic signed [WB-1:0] q_mag;
  logic signed [WB-1:0] p_lo;
  logic signed [WB-1:0] p_hi;
  logic                 bad_box;

  function automatic logic signed [CW-1:0] coord(input logic [FieldBits-1:0] v);
    return CW'(v);
  endfunction

  always_comb begin
    num      = second ? (NB'(hi[axis]) - NB'(org[axis])) : (NB'(lo[axis]) - NB'(org[axis]));
    den_s    = dir[axis];
    num_mag  = num[NB-1] ? NB'(-num) : num;
    den_mag  = den_s[CW-1] ? CW'(-den_s) : den_s;
    num_zero = (num == '0);
    neg      = num[NB-1] ^ den_s[CW-1];
    q_mag    = WB'({1'b0, quot});
    if (num_zero) slab = '0;
    else if (!neg) slab = (q_mag > SatMax) ? SatMax : q_mag;
    else begin
      slab = -(q_mag + WB'(rem_nz));
      if (slab < SatMin) slab = SatMin;
    end
    p_lo = (p_val < slab) ? p_val : slab;
    p_hi = (p_val < slab) ? slab : p_val;
    bad_box = (lo[0] > hi[0]) || (lo[1] > hi[1]) || (lo[2] > hi[2]);
  end

  assign start    = (state == S_AXIS) && (axis != 2'd3) && (dir[axis] != '0);
  assign in_ready = (state == S_IDLE);
  assign res.valid = (state == S_OUT);
  assign res.data  = '{status: status, t_enter: t_out};

  rbsi_divider #(.NUM_BITS(NB), .DEN_BITS(CW), .FRAC_BITS(FRACTION_BITS)) u_div (
    .clk(clk), .rst(rst), .start(start), .num_mag(num_mag), .den_mag(den_mag),
    .done(done), .quot(quot), .rem_nz(rem_nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
        dir[i] <= '0;
      end
      lim <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          if (in_data.mode == MODE_LOAD) begin
            org[0] <= coord(in_data.first_x);
            org[1] <= coord(in_data.first_y);
            org[2] <= coord(in_data.first_z);
            dir[0] <= coord(in_data.second_x);
            dir[1] <= coord(in_data.second_y);
            dir[2] <= coord(in_data.second_z);
            lim    <= in_data.limit;
          end else begin
            lo[0] <= coord(in_data.first_x);
            lo[1] <= coord(in_data.first_y);
            lo[2] <= coord(in_data.first_z);
            hi[0] <= coord(in_data.second_x);
            hi[1] <= coord(in_data.second_y);
            hi[2] <= coord(in_data.second_z);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          status <= STATUS_INVALID;
          t_out  <= '0;
          t_min  <= '0;
          t_max  <= WB'(lim);
          axis   <= 2'd0;
          second <= 1'b0;
          if ((dir[0] == '0 && dir[1] == '0 && dir[2] == '0) || bad_box) state <= S_OUT;
          else state <= S_AXIS;
        end
        S_AXIS: begin
          if (axis == 2'd3) begin
            status <= STATUS_HIT;
            t_out  <= LimitBits'(t_min);
            state  <= S_OUT;
          end else if (dir[axis] == '0) begin
            if (org[axis] < lo[axis] || org[axis] > hi[axis]) begin
              status <= STATUS_MISS;
              state  <= S_OUT;
            end else axis <= axis + 2'd1;
          end else state <= S_WAIT;
        end
        S_WAIT: if (done) begin
          if (!second) begin
            p_val  <= slab;
            second <= 1'b1;
            state  <= S_AXIS;
          end else state <= S_MERGE;
        end
        S_MERGE: begin
          second <= 1'b0;
          if (((p_lo > t_min) ? p_lo : t_min) > ((p_hi < t_max) ? p_hi : t_max)) begin
            status <= STATUS_MISS;
            state  <= S_OUT;
          end else begin
            if (p_lo > t_min) t_min <= p_lo;
            if (p_hi < t_max) t_max <= p_hi;
            axis  <= axis + 2'd1;
            state <= S_AXIS;
          end
        end
        S_OUT: if (res.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/ray_box_slab_intersect.sv
// Ray against axis-aligned box, slab test in signed fixed point.
// Channel in carries items: mode 0 loads ray origin, direction and limit
// and gives no result; mode 1 tests a box and gives one result beat on out.
// Results leave in the order their items were accepted.
// A two-entry queue sits behind the input port, so up to two items are
// taken while the back end is busy. The back end works one item at a time.
// A test works each axis with nonzero direction by two divisions on the one
// shared radix-2 divider and one merge step.
// When out stalls, the result is held and the back end waits; the queue
// keeps taking items until full.
// Reset clears the stored ray to zero, so tests report invalid until a load.
module ray_box_slab_intersect #(
  parameter int COORD_BITS = 32,
  parameter int FRACTION_BITS = 16
) (
  input logic           clk,
  input logic           rst,
  rbsi_item_if.sink     in,
  rbsi_result_if.source out
);
  import rbsi_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_data;

  rbsi_queue #(.WIDTH($bits(item_t))) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready), .in_data(in.data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  rbsi_back #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .res(out)
  );

  a_status: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> (out.data.status != 2'd3))
    else $error("reserved status code");
  a_tzero: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.data.status != STATUS_HIT) |-> (out.data.t_enter == '0))
    else $error("t_enter nonzero without hit");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> (out.valid && $stable(out.data)))
    else $error("result changed under stall");
endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rbsi_pkg::*;

  // Floor division of num * 2^16 by den, clamped to the 48-bit signed range.
  function automatic longint slab_quotient(longint num, longint den);
    logic [63:0] a, b, q, r;
    logic neg, sat;
    longint sat_mag;
    sat_mag = 64'sd1 <<< 47;
    if (num == 0) return 0;
    a = num < 0 ? -num : num;
    b = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    q = a / b;
    r = a % b;
    sat = q > (64'd1 << 31);
    if (!sat) begin
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= b) begin
          r = r - b;
          q[0] = 1'b1;
        end
      end
    end
    if (!neg) begin
      if (sat || q > sat_mag - 1) return sat_mag - 1;
      return q;
    end
    if (sat) return -sat_mag;
    if (r != 0) q = q + 1;
    if (q > sat_mag) return -sat_mag;
    return -longint'(q);
  endfunction

  class box_scoreboard;
    longint org[3];
    longint dir[3];
    longint lim;
    result_t pending[$];
    int mismatches;

    function void note_item(item_t it);
      longint lo[3], hi[3], t_lo, t_hi, p, q, tmp;
      result_t res;
      if (it.mode == MODE_LOAD) begin
        org[0] = it.first_x; org[1] = it.first_y; org[2] = it.first_z;
        dir[0] = it.second_x; dir[1] = it.second_y; dir[2] = it.second_z;
        lim = it.limit;
        return;
      end
      lo[0] = it.first_x; lo[1] = it.first_y; lo[2] = it.first_z;
      hi[0] = it.second_x; hi[1] = it.second_y; hi[2] = it.second_z;
      res.status = STATUS_INVALID;
      res.t_enter = '0;
      if (dir[0] == 0 && dir[1] == 0 && dir[2] == 0) begin
        pending.push_back(res);
        return;
      end
      for (int i = 0; i < 3; i++) begin
        if (lo[i] > hi[i]) begin
          pending.push_back(res);
          return;
        end
      end
      res.status = STATUS_MISS;
      t_lo = 0;
      t_hi = lim;
      for (int i = 0; i < 3; i++) begin
        if (dir[i] == 0) begin
          if (org[i] < lo[i] || org[i] > hi[i]) begin
            pending.push_back(res);
            return;
          end
          continue;
        end
        p = slab_quotient(lo[i] - org[i], dir[i]);
        q = slab_quotient(hi[i] - org[i], dir[i]);
        if (p > q) begin
          tmp = p; p = q; q = tmp;
        end
        if (p > t_lo) t_lo = p;
        if (q < t_hi) t_hi = q;
        if (t_lo > t_hi) begin
          pending.push_back(res);
          return;
        end
      end
      res.status = STATUS_HIT;
      res.t_enter = t_lo[30:0];
      pending.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0h", got.status, got.t_enter);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.t_enter !== want.t_enter) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %0d/%0h got %0d/%0h",
                   want.status, want.t_enter, got.status, got.t_enter);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int send_idle_pct;
  int recv_idle_pct;
  box_scoreboard board;

  rbsi_item_if in_ch ();
  rbsi_result_if out_ch ();

  ray_box_slab_intersect u_dut (
    .clk(clk),
    .rst(rst),
    .in (in_ch.sink),
    .out(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) board.note_item(in_ch.data);
    if (!rst && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
  end

  always @(negedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // The beat stays offered after acceptance until the next send or a drain
  // replaces or drops it at the following falling edge.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(3);
      2: return 32'h7fff_fff0 | $urandom_range(15);
      default: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic item_t load_item(logic [31:0] ox, oy, oz, dx, dy, dz, logic [30:0] lim);
    item_t it;
    it.mode = MODE_LOAD;
    it.first_x = ox; it.first_y = oy; it.first_z = oz;
    it.second_x = dx; it.second_y = dy; it.second_z = dz;
    it.limit = lim;
    return it;
  endfunction

  function automatic item_t box_item(logic [31:0] ax, ay, az, bx, by, bz);
    item_t it;
    it = load_item(ax, ay, az, bx, by, bz, 31'($urandom));
    it.mode = MODE_TEST;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    logic [31:0] a, b;
    logic [31:0] c[6];
    if ($urandom_range(9) < 2) begin
      it = load_item(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), 31'($urandom));
      for (int i = 0; i < 3; i++)
        if ($urandom_range(3) == 0) begin
          if (i == 0) it.second_x = '0;
          if (i == 1) it.second_y = '0;
          if (i == 2) it.second_z = '0;
        end
      if ($urandom_range(1)) it.limit = 31'h7fff_ffff;
      return it;
    end
    // Ordered boxes mostly, so the slab work is reached; some are reversed.
    for (int i = 0; i < 3; i++) begin
      a = pick_coord();
      b = pick_coord();
      if ($signed(a) > $signed(b) && $urandom_range(15) != 0) begin
        c[i] = b; c[i + 3] = a;
      end else begin
        c[i] = a; c[i + 3] = b;
      end
    end
    return box_item(c[0], c[1], c[2], c[3], c[4], c[5]);
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  initial begin
    item_t it;
    board = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero ray is invalid, reversed boxes, zero-direction axes,
    // extremes, saturation and empty intervals.
    send_item(box_item(0, 0, 0, 1, 1, 1));
    send_item(load_item(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h7fff_ffff));
    send_item(box_item(32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                       32'h0004_0000, 32'h0004_0000, 32'h0004_0000));
    send_item(box_item(5, 0, 0, 4, 1, 1));
    send_item(box_item(0, 0, 5, 1, 1, 4));
    send_item(box_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_item(box_item(32'hffff_0000, 32'h0003_0000, 0, 32'h0001_0000, 32'h0004_0000, 1));
    send_item(load_item(32'h0000_8000, 0, 32'h8000_0000, 32'h0000_0001, 0, 0, 31'h0010_0000));
    send_item(box_item(32'h7fff_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_item(box_item(0, 1, 0, 32'h0001_0000, 2, 1));
    send_item(box_item(32'h8000_0000, 0, 32'h8000_0001, 32'h7fff_ffff, 0, 0));
    send_item(load_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'hffff_ffff, 32'h8000_0000, 31'h7fff_ffff));
    send_item(box_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_item(box_item(0, 0, 0, 32'h0000_0003, 32'h0000_0007, 32'h0001_0000));
    send_item(load_item(0, 0, 0, 32'hfffd_0000, 32'h0000_0003, 32'h0000_0000, 0));
    send_item(box_item(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
                       32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_item(box_item(32'hffff_0001, 32'hffff_0001, 32'hffff_0001,
                       32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 23 : (phase == 1 ? 66 : 0);
      recv_idle_pct = phase == 0 ? 66 : (phase == 1 ? 23 : 0);
      for (int n = 0; n < 480; n++) begin
        it = random_item();
        send_item(it);
        if (n == 200) wait_drained();
      end
      wait_drained();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
